### rtl/mmu_pkg.sv
`timescale 1ns / 1ps

package mmu_pkg;

    // Operand and result width
    localparam int WIDTH = 32;
    // Full product width
    localparam int PROD_WIDTH = 2 * WIDTH;
    // One reduction cell per product bit
    localparam int NUM_CELLS = PROD_WIDTH;

    localparam int FUNC_WIDTH = 2;

    // Operation codes
    localparam logic [FUNC_WIDTH-1:0] FUNC_ADD = 2'd0;
    localparam logic [FUNC_WIDTH-1:0] FUNC_SUB = 2'd1;
    localparam logic [FUNC_WIDTH-1:0] FUNC_MUL = 2'd2;

    // Modulus after reset
    localparam logic [WIDTH-1:0] MODULUS_RESET = 32'd1000000007;

    // Beat carried from cell to cell
    typedef struct packed {
        logic                  mul;   // residue still being reduced
        logic [WIDTH-1:0]      rem;   // partial remainder, or final add/sub result
        logic [PROD_WIDTH-1:0] prod;  // product bits not yet shifted in, MSB first
    } cell_data_t;

endpackage

### rtl/mmu_cmd_if.sv
`timescale 1ns / 1ps

interface mmu_cmd_if;
    logic                            valid;
    logic                            ready;
    logic [mmu_pkg::FUNC_WIDTH-1:0]  func;
    logic [mmu_pkg::WIDTH-1:0]       operand_a;
    logic [mmu_pkg::WIDTH-1:0]       operand_b;

    modport source (output valid, output func, output operand_a, output operand_b,
                    input ready);
    modport sink (input valid, input func, input operand_a, input operand_b,
                  output ready);
endinterface

### rtl/mmu_rsp_if.sv
`timescale 1ns / 1ps

interface mmu_rsp_if;
    logic                      valid;
    logic                      ready;
    logic [mmu_pkg::WIDTH-1:0] residue;

    modport source (output valid, output residue, input ready);
    modport sink (input valid, input residue, output ready);
endinterface

### rtl/mmu_front.sv
`timescale 1ns / 1ps

module mmu_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [mmu_pkg::WIDTH-1:0]     modulus,
    mmu_cmd_if.sink                       cmd,
    output logic                          down_valid,
    output mmu_pkg::cell_data_t           down_data,
    input  logic                          down_ready
);

    localparam int W = mmu_pkg::WIDTH;

    logic                valid_reg;
    mmu_pkg::cell_data_t data_reg;
    mmu_pkg::cell_data_t data_next;
    logic                up_ready;

    logic [W:0]          sum;
    logic [W:0]          sum_red;
    logic [W-1:0]        add_res;
    logic [W-1:0]        sub_res;

    // Take a new beat when empty or when the held one moves on
    assign up_ready  = !valid_reg || down_ready;
    assign cmd.ready = up_ready;

    // Add with one conditional subtract of the modulus
    assign sum     = {1'b0, cmd.operand_a} + {1'b0, cmd.operand_b};
    assign sum_red = sum - {1'b0, modulus};
    assign add_res = (sum >= {1'b0, modulus}) ? sum_red[W-1:0] : sum[W-1:0];

    // Subtract with one conditional add of the modulus
    always_comb
    begin
        sub_res = cmd.operand_a - cmd.operand_b;
        if (cmd.operand_a < cmd.operand_b)
        begin
            sub_res = sub_res + modulus;
        end
    end

    // Decode the operation; multiply starts the cell chain from a zero remainder
    always_comb
    begin
        data_next.mul  = 1'b0;
        data_next.rem  = '0;
        data_next.prod = '0;
        unique case (cmd.func)
            mmu_pkg::FUNC_ADD:
            begin
                data_next.rem = add_res;
            end
            mmu_pkg::FUNC_SUB:
            begin
                data_next.rem = sub_res;
            end
            mmu_pkg::FUNC_MUL:
            begin
                data_next.mul  = 1'b1;
                data_next.prod = {{W{1'b0}}, cmd.operand_a} * {{W{1'b0}}, cmd.operand_b};
            end
            default:
            begin
                data_next.rem = '0;
            end
        endcase
    end

    // Hold the valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= cmd.valid;
        end
    end

    // Load the payload on an accepted beat
    always_ff @(posedge clk)
    begin
        if (up_ready && cmd.valid)
        begin
            data_reg <= data_next;
        end
    end

    assign down_valid = valid_reg;
    assign down_data  = data_reg;

    property p_accept_fills;
        @(posedge clk) disable iff (!rst_n)
        cmd.valid && cmd.ready |=> valid_reg;
    endproperty
    a_accept_fills: assert property (p_accept_fills)
        else $error("accepted beat did not reach the front stage");

    property p_front_hold;
        @(posedge clk) disable iff (!rst_n)
        valid_reg && !down_ready |=> valid_reg && $stable(data_reg);
    endproperty
    a_front_hold: assert property (p_front_hold)
        else $error("front stage lost a stalled beat");

endmodule

### rtl/mmu_cell.sv
`timescale 1ns / 1ps

module mmu_cell
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [mmu_pkg::WIDTH-1:0] modulus,
    input  logic                      up_valid,
    input  mmu_pkg::cell_data_t       up_data,
    output logic                      up_ready,
    output logic                      down_valid,
    output mmu_pkg::cell_data_t       down_data,
    input  logic                      down_ready
);

    localparam int W = mmu_pkg::WIDTH;
    localparam int P = mmu_pkg::PROD_WIDTH;

    logic                valid_reg;
    mmu_pkg::cell_data_t data_reg;
    mmu_pkg::cell_data_t data_next;

    logic [W:0]          shifted;
    logic [W:0]          reduced;

    // Shift the next product bit into the remainder, subtract the modulus once
    assign shifted = {up_data.rem, up_data.prod[P-1]};
    assign reduced = shifted - {1'b0, modulus};

    always_comb
    begin
        data_next      = up_data;
        data_next.prod = {up_data.prod[P-2:0], 1'b0};
        if (up_data.mul)
        begin
            if (shifted >= {1'b0, modulus})
            begin
                data_next.rem = reduced[W-1:0];
            end
            else
            begin
                data_next.rem = shifted[W-1:0];
            end
        end
    end

    // Advance when empty or when the next cell takes the held beat
    assign up_ready = !valid_reg || down_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign down_valid = valid_reg;
    assign down_data  = data_reg;

    property p_cell_hold;
        @(posedge clk) disable iff (!rst_n)
        valid_reg && !down_ready |=> valid_reg && $stable(data_reg);
    endproperty
    a_cell_hold: assert property (p_cell_hold)
        else $error("cell dropped or changed a stalled beat");

    property p_passthrough_clean;
        @(posedge clk) disable iff (!rst_n)
        up_valid && up_ready && !up_data.mul && up_data.prod == '0
            |=> !data_reg.mul && data_reg.prod == '0 && data_reg.rem == $past(up_data.rem);
    endproperty
    a_passthrough_clean: assert property (p_passthrough_clean)
        else $error("add or subtract result altered in the cell chain");

endmodule

### rtl/modular_add_sub_mul_unit_top.sv
`timescale 1ns / 1ps

// Modular add, subtract and multiply unit. Each command beat carries func
// (0 add, 1 subtract, 2 multiply, 3 returns zero) and two 32-bit operands and
// yields one residue beat modulo the modulus register (reset 1000000007,
// written through cfg_wr_en / cfg_wr_data; the user must write it only while
// no beat is in flight, which the block does not enforce). Add and subtract
// apply a single correction by the modulus; multiply reduces the full 64-bit
// product completely, and with a zero modulus returns the low 32 bits of the
// product. The unit accepts one beat every cycle when the response side does
// not stall and returns results in order: one front stage forms the product
// and the add/subtract results, then a chain of 64 reduction cells shifts in
// one product bit each, doing one compare and subtract per cell. Each stage
// holds its beat under backpressure and empty stages keep filling, so stalls
// on the response side do not block commands until the whole chain is full.
// No clearing is needed after reset.
module modular_add_sub_mul_unit_top
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [mmu_pkg::WIDTH-1:0] cfg_wr_data,
    mmu_cmd_if.sink                   cmd,
    mmu_rsp_if.source                 rsp
);

    localparam int N = mmu_pkg::NUM_CELLS;

    logic [mmu_pkg::WIDTH-1:0] modulus_reg;

    logic [N:0]                stage_valid;
    logic [N:0]                stage_ready;
    mmu_pkg::cell_data_t       stage_data [N+1];

    // Hold the modulus
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= mmu_pkg::MODULUS_RESET;
        end
        else if (cfg_wr_en)
        begin
            modulus_reg <= cfg_wr_data;
        end
    end

    // Decode and multiply
    mmu_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .modulus    (modulus_reg),
        .cmd        (cmd),
        .down_valid (stage_valid[0]),
        .down_data  (stage_data[0]),
        .down_ready (stage_ready[0])
    );

    // Reduce the product one bit per cell
    for (genvar i = 0; i < N; i++)
    begin : g_cell
        mmu_cell u_cell
        (
            .clk        (clk),
            .rst_n      (rst_n),
            .modulus    (modulus_reg),
            .up_valid   (stage_valid[i]),
            .up_data    (stage_data[i]),
            .up_ready   (stage_ready[i]),
            .down_valid (stage_valid[i+1]),
            .down_data  (stage_data[i+1]),
            .down_ready (stage_ready[i+1])
        );
    end

    // Drive the response beat from the last cell
    assign rsp.valid      = stage_valid[N];
    assign rsp.residue    = stage_data[N].rem;
    assign stage_ready[N] = rsp.ready;

    property p_rsp_hold;
        @(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.residue);
    endproperty
    a_rsp_hold: assert property (p_rsp_hold)
        else $error("response beat changed while stalled");

endmodule
